// ===== rtl/core/ktc_pkg.sv =====
package ktc_pkg;

  // Field widths of the command and result transfers.
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned KEY_W      = 40;
  localparam int unsigned LEAD_W     = 8;
  localparam int unsigned TAIL_W     = KEY_W - LEAD_W;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_IDX_W = 6;

  // Default table size.
  localparam int unsigned NUM_SLOTS_DEF = 64;

  // Lead byte values that mark a free slot and a defrag hole.
  localparam logic [LEAD_W-1:0] FREE_BYTE = 8'hFF;
  localparam logic [LEAD_W-1:0] ZERO_BYTE = 8'h00;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_DEFRAG = 3'd3,
    CMD_FORMAT = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_DUP       = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

endpackage

// ===== rtl/core/ktc_ram.sv =====
module ktc_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/key_table_with_compaction_top.sv =====
// Channel   Direction  Handshake                  Payload
// command   in         in_valid_i / in_stall_o    command_i, key_i
// result    out        out_valid_o / out_stall_i  status_o, found_o, slot_index_o
//
// One command at a time: in_stall_o stays high from a command transfer until its
// result is loaded into the output register. Insert, remove and lookup read and
// check the slots in turn; format frees them in turn; defrag fills each hole from
// a later used slot. After reset a clearing pass sets every byte to 0xFF first.
// A stalled result holds back only the handover of the next result.
module key_table_with_compaction_top
  import ktc_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [KEY_W-1:0]      key_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic                  found_o,
  output logic [SLOT_IDX_W-1:0] slot_index_o
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_SLOTS - 1);
  localparam logic [CNT_W-1:0] END_CNT  = CNT_W'(NUM_SLOTS);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_CHK,
    S_FMT,
    S_D_RDI,
    S_D_CHKI,
    S_D_RDJ,
    S_D_CHKJ,
    S_D_CLRJ,
    S_RESP
  } state_e;

  state_e                state_q, state_d;
  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [CNT_W-1:0]      src_q, src_d;
  logic                  free_found_q, free_found_d;
  logic [IDX_W-1:0]      free_idx_q, free_idx_d;
  status_e               res_status_q, res_status_d;
  logic                  res_found_q, res_found_d;
  logic [IDX_W-1:0]      res_slot_q, res_slot_d;
  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;
  logic                  out_found_q, out_found_d;
  logic [SLOT_IDX_W-1:0] out_slot_q, out_slot_d;

  // Slot memory, split into the lead byte and the four trailing bytes.
  logic              lead_we, tail_we;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [LEAD_W-1:0] lead_wdata, lead_rdata;
  logic [TAIL_W-1:0] tail_wdata, tail_rdata;

  ktc_ram #(
    .WIDTH (LEAD_W),
    .DEPTH (NUM_SLOTS),
    .ADDR_W(IDX_W)
  ) u_lead_ram (
    .clk_i  (clk_i),
    .we_i   (lead_we),
    .waddr_i(wr_addr),
    .wdata_i(lead_wdata),
    .raddr_i(rd_addr),
    .rdata_o(lead_rdata)
  );

  ktc_ram #(
    .WIDTH (TAIL_W),
    .DEPTH (NUM_SLOTS),
    .ADDR_W(IDX_W)
  ) u_tail_ram (
    .clk_i  (clk_i),
    .we_i   (tail_we),
    .waddr_i(wr_addr),
    .wdata_i(tail_wdata),
    .raddr_i(rd_addr),
    .rdata_o(tail_rdata)
  );

  // Shared compare unit on the slot that was just read.
  logic             key_hit, lead_free, lead_hole, last_idx;
  logic [CNT_W-1:0] idx_inc, src_inc, search_start;

  assign key_hit      = ({lead_rdata, tail_rdata} == key_q);
  assign lead_free    = (lead_rdata == FREE_BYTE);
  assign lead_hole    = lead_free || (lead_rdata == ZERO_BYTE);
  assign last_idx     = (idx_q == LAST_CNT);
  assign idx_inc      = idx_q + CNT_W'(1);
  assign src_inc      = src_q + CNT_W'(1);
  assign search_start = (src_q > idx_inc) ? src_q : idx_inc;

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    idx_d        = idx_q;
    src_d        = src_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_slot_d   = out_slot_q;

    lead_we    = 1'b0;
    tail_we    = 1'b0;
    wr_addr    = idx_q[IDX_W-1:0];
    rd_addr    = idx_q[IDX_W-1:0];
    lead_wdata = FREE_BYTE;
    tail_wdata = '1;

    // A result leaves on a transfer at the output.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // Clearing pass after reset: every byte of every slot becomes 0xFF.
      S_INIT: begin
        lead_we = 1'b1;
        tail_we = 1'b1;
        if (last_idx) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_inc;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = command_i;
          key_d        = key_i;
          idx_d        = '0;
          src_d        = '0;
          free_found_d = 1'b0;
          res_status_d = ST_DONE;
          res_found_d  = 1'b0;
          res_slot_d   = '0;
          case (command_i)
            CMD_INSERT, CMD_REMOVE, CMD_LOOKUP: state_d = S_RD;
            CMD_DEFRAG:                         state_d = S_D_RDI;
            CMD_FORMAT:                         state_d = S_FMT;
            default:                            state_d = S_RESP;
          endcase
        end
      end

      S_RD: begin
        state_d = S_CHK;
      end

      // Key scan; insert also remembers the lowest free slot on the way.
      S_CHK: begin
        if (key_hit) begin
          res_found_d  = 1'b1;
          res_slot_d   = idx_q[IDX_W-1:0];
          res_status_d = (cmd_q == CMD_INSERT) ? ST_DUP : ST_DONE;
          if (cmd_q == CMD_REMOVE) begin
            lead_we = 1'b1;
          end
          state_d = S_RESP;
        end else begin
          if (lead_free && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = idx_q[IDX_W-1:0];
          end
          if (last_idx) begin
            state_d = S_RESP;
            if (cmd_q == CMD_INSERT) begin
              if (free_found_q || lead_free) begin
                lead_we      = 1'b1;
                tail_we      = 1'b1;
                wr_addr      = free_found_q ? free_idx_q : idx_q[IDX_W-1:0];
                lead_wdata   = key_q[KEY_W-1:TAIL_W];
                tail_wdata   = key_q[TAIL_W-1:0];
                res_status_d = ST_DONE;
                res_slot_d   = free_found_q ? free_idx_q : idx_q[IDX_W-1:0];
              end else begin
                res_status_d = ST_FULL;
              end
            end else begin
              res_status_d = ST_NOT_FOUND;
            end
          end else begin
            idx_d   = idx_inc;
            state_d = S_RD;
          end
        end
      end

      // Format frees every slot through its lead byte only.
      S_FMT: begin
        lead_we = 1'b1;
        if (last_idx) begin
          state_d = S_RESP;
        end else begin
          idx_d = idx_inc;
        end
      end

      S_D_RDI: begin
        state_d = S_D_CHKI;
      end

      // Defrag: idx walks the holes, src only moves forward over sources.
      S_D_CHKI: begin
        if (!lead_hole) begin
          if (last_idx) begin
            state_d = S_RESP;
          end else begin
            idx_d   = idx_inc;
            state_d = S_D_RDI;
          end
        end else if (search_start == END_CNT) begin
          state_d = S_RESP;
        end else begin
          src_d   = search_start;
          state_d = S_D_RDJ;
        end
      end

      S_D_RDJ: begin
        rd_addr = src_q[IDX_W-1:0];
        state_d = S_D_CHKJ;
      end

      S_D_CHKJ: begin
        if (!lead_hole) begin
          lead_we    = 1'b1;
          tail_we    = 1'b1;
          lead_wdata = lead_rdata;
          tail_wdata = tail_rdata;
          state_d    = S_D_CLRJ;
        end else begin
          src_d   = src_inc;
          state_d = (src_inc == END_CNT) ? S_RESP : S_D_RDJ;
        end
      end

      // The copied source slot becomes free.
      S_D_CLRJ: begin
        lead_we = 1'b1;
        wr_addr = src_q[IDX_W-1:0];
        src_d   = src_inc;
        if (last_idx) begin
          state_d = S_RESP;
        end else begin
          idx_d   = idx_inc;
          state_d = S_D_RDI;
        end
      end

      // Hand the result over once the output register is free.
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          out_slot_d   = SLOT_IDX_W'(res_slot_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      cmd_q        <= '0;
      key_q        <= '0;
      idx_q        <= '0;
      src_q        <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      res_status_q <= ST_DONE;
      res_found_q  <= 1'b0;
      res_slot_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_found_q  <= 1'b0;
      out_slot_q   <= '0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      key_q        <= key_d;
      idx_q        <= idx_d;
      src_q        <= src_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
      res_slot_q   <= res_slot_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_found_q  <= out_found_d;
      out_slot_q   <= out_slot_d;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign found_o      = out_found_q;
  assign slot_index_o = out_slot_q;

  // The table is never written while the block waits for a command.
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!lead_we && !tail_we))
    else $error("slot memory written while idle");

  // An accepted command keeps the input stalled in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a command transfer");

  // A duplicate always reports the matching slot as found.
  a_dup_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_DUP)) |-> found_o)
    else $error("duplicate result without found");

  // Full table and missing key carry neither found nor a slot number.
  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((status_o == ST_FULL) || (status_o == ST_NOT_FOUND)))
      |-> (!found_o && (slot_index_o == '0)))
    else $error("miss result carries found or a slot number");

  // The defrag source always lies beyond the hole being filled.
  a_src_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_D_CHKJ) || (state_q == S_D_CLRJ)) |-> (src_q > idx_q))
    else $error("defrag source not beyond the hole");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb
  import ktc_pkg::*;
();

  localparam int unsigned TBL_SLOTS   = NUM_SLOTS_DEF;
  localparam int unsigned ITEM_GOAL   = 850;
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam int unsigned TAIL_CYCLES = 10 * TBL_SLOTS;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    bit               drain;
  } table_cmd_t;

  typedef struct packed {
    status_e               status;
    logic                  found;
    logic [SLOT_IDX_W-1:0] slot;
  } table_reply_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [CMD_W-1:0]      command_i = '0;
  logic [KEY_W-1:0]      key_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic                  found_o;
  logic [SLOT_IDX_W-1:0] slot_index_o;

  // Mirror of the slot memory, plus the traffic bookkeeping.
  logic [KEY_W-1:0] slot_tbl [TBL_SLOTS];
  table_cmd_t       cmd_backlog [$];
  table_reply_t     expected_replies [$];
  logic [KEY_W-1:0] key_pool [$];
  int               cmds_offered = 0;
  int               cmds_accepted = 0;
  int               replies_seen = 0;
  int               fail_cnt = 0;
  int               items_queued = 0;

  key_table_with_compaction_top #(
    .NUM_SLOTS(TBL_SLOTS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .key_i        (key_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .found_o      (found_o),
    .slot_index_o (slot_index_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit is_hole(logic [KEY_W-1:0] v);
    return v[KEY_W-1:TAIL_W] == ZERO_BYTE || v[KEY_W-1:TAIL_W] == FREE_BYTE;
  endfunction

  // Applies one command to the mirrored table and returns the reply it should give.
  function automatic table_reply_t apply_table_cmd(logic [CMD_W-1:0] cmd,
                                                    logic [KEY_W-1:0] key);
    table_reply_t r;
    int           hit;
    int           free_slot;
    bit           moved;
    r = '{status: ST_DONE, found: 1'b0, slot: '0};
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < TBL_SLOTS; i++) begin
      if (hit < 0 && slot_tbl[i] == key) hit = i;
      if (free_slot < 0 && slot_tbl[i][KEY_W-1:TAIL_W] == FREE_BYTE) free_slot = i;
    end
    case (cmd)
      CMD_INSERT: begin
        if (hit >= 0) begin
          r.status = ST_DUP;
          r.found  = 1'b1;
          r.slot   = SLOT_IDX_W'(hit);
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          slot_tbl[free_slot] = key;
          r.slot = SLOT_IDX_W'(free_slot);
        end
      end
      CMD_REMOVE, CMD_LOOKUP: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          r.slot  = SLOT_IDX_W'(hit);
          if (cmd == CMD_REMOVE) slot_tbl[hit][KEY_W-1:TAIL_W] = FREE_BYTE;
        end
      end
      CMD_DEFRAG: begin
        // Each hole pulls in the next later used slot, which is then freed.
        for (int i = 0; i < TBL_SLOTS; i++) begin
          if (is_hole(slot_tbl[i])) begin
            moved = 1'b0;
            for (int j = i + 1; j < TBL_SLOTS; j++) begin
              if (!moved && !is_hole(slot_tbl[j])) begin
                slot_tbl[i] = slot_tbl[j];
                slot_tbl[j][KEY_W-1:TAIL_W] = FREE_BYTE;
                moved = 1'b1;
              end
            end
          end
        end
      end
      CMD_FORMAT: begin
        for (int i = 0; i < TBL_SLOTS; i++) slot_tbl[i][KEY_W-1:TAIL_W] = FREE_BYTE;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Fresh key with the lead byte and tail biased toward their extremes.
  function automatic logic [KEY_W-1:0] fresh_key(bit no_free_lead);
    logic [LEAD_W-1:0] lead;
    logic [TAIL_W-1:0] tail;
    int                pick;
    pick = $urandom_range(0, 9);
    if (no_free_lead) lead = LEAD_W'($urandom_range(0, 254));
    else if (pick == 0) lead = ZERO_BYTE;
    else if (pick == 1) lead = FREE_BYTE;
    else lead = LEAD_W'($urandom);
    pick = $urandom_range(0, 19);
    if (pick == 0) tail = '0;
    else if (pick == 1) tail = '1;
    else tail = TAIL_W'($urandom);
    return {lead, tail};
  endfunction

  // Key taken from earlier traffic, sometimes with the lead byte of a freed slot.
  function automatic logic [KEY_W-1:0] pool_key();
    logic [KEY_W-1:0] k;
    if (key_pool.size() == 0) return fresh_key(1'b0);
    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    if ($urandom_range(0, 4) == 0) k[KEY_W-1:TAIL_W] = FREE_BYTE;
    return k;
  endfunction

  task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key, bit drain);
    table_cmd_t c;
    c.cmd = cmd;
    c.key = key;
    c.drain = drain;
    cmd_backlog.push_back(c);
    items_queued++;
    if (cmd == CMD_INSERT) begin
      key_pool.push_back(key);
      if (key_pool.size() > 96) void'(key_pool.pop_front());
    end
  endtask

  // Fills the table past its capacity, then thins it out and compacts it.
  task automatic queue_fill_run();
    if ($urandom_range(0, 1) == 0) queue_cmd(CMD_FORMAT, fresh_key(1'b0), 1'b0);
    for (int i = 0; i < TBL_SLOTS + 6; i++) queue_cmd(CMD_INSERT, fresh_key(1'b1), 1'b0);
    for (int i = 0; i < 6; i++) queue_cmd(CMD_REMOVE, pool_key(), 1'b0);
    queue_cmd(CMD_DEFRAG, fresh_key(1'b0), 1'b0);
  endtask

  // Stimulus, then the end-of-run check.
  initial begin
    int pick;
    bit drain;
    for (int i = 0; i < TBL_SLOTS; i++) slot_tbl[i] = '1;

    // Directed: empty slots match, duplicates, lead bytes 0 and 255, defrag, format and unknown commands.
    queue_cmd(CMD_LOOKUP, 40'hFF_FFFF_FFFF, 1'b0);
    queue_cmd(CMD_LOOKUP, 40'h00_0000_0000, 1'b0);
    queue_cmd(CMD_REMOVE, 40'h00_0000_0000, 1'b0);
    queue_cmd(CMD_INSERT, 40'h00_0000_0000, 1'b0);
    queue_cmd(CMD_INSERT, 40'h00_0000_0000, 1'b0);
    queue_cmd(CMD_INSERT, 40'hFF_FFFF_FFFF, 1'b0);
    queue_cmd(CMD_INSERT, 40'h12_3456_789A, 1'b0);
    queue_cmd(CMD_INSERT, 40'h80_0000_0001, 1'b0);
    queue_cmd(CMD_INSERT, 40'hFE_FFFF_FFFF, 1'b0);
    queue_cmd(CMD_INSERT, 40'h01_0000_0000, 1'b0);
    queue_cmd(CMD_LOOKUP, 40'h80_0000_0001, 1'b0);
    queue_cmd(CMD_REMOVE, 40'h12_3456_789A, 1'b0);
    queue_cmd(CMD_LOOKUP, 40'hFF_3456_789A, 1'b0);
    queue_cmd(CMD_REMOVE, 40'h00_0000_0000, 1'b0);
    queue_cmd(CMD_DEFRAG, 40'h00_0000_0000, 1'b0);
    queue_cmd(CMD_INSERT, 40'h00_AAAA_AAAA, 1'b0);
    queue_cmd(CMD_DEFRAG, 40'hFF_FFFF_FFFF, 1'b0);
    queue_cmd(CMD_LOOKUP, 40'h00_AAAA_AAAA, 1'b0);
    queue_cmd(CMD_FORMAT, 40'h55_5555_5555, 1'b0);
    queue_cmd(CMD_LOOKUP, 40'h80_0000_0001, 1'b0);
    queue_cmd(CMD_LOOKUP, 40'hFF_0000_0001, 1'b0);
    queue_cmd(CMD_W'(CMD_FORMAT + 1), 40'hAA_AAAA_AAAA, 1'b0);
    queue_cmd('1, 40'hFF_FFFF_FFFF, 1'b0);
    queue_cmd(CMD_W'(CMD_FORMAT + 2), 40'h00_0000_0000, 1'b0);

    // Random part: the sender first waits for the table to go quiet, then fills it.
    queue_cmd(CMD_LOOKUP, pool_key(), 1'b1);
    queue_fill_run();
    while (items_queued < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      drain = ($urandom_range(0, 99) == 0);
      if (pick < 2) queue_fill_run();
      else if (pick < 45)
        queue_cmd(CMD_INSERT, ($urandom_range(0, 9) < 7) ? fresh_key(1'b0) : pool_key(), drain);
      else if (pick < 65)
        queue_cmd(CMD_LOOKUP, ($urandom_range(0, 9) < 7) ? pool_key() : fresh_key(1'b0), drain);
      else if (pick < 85)
        queue_cmd(CMD_REMOVE, ($urandom_range(0, 9) < 7) ? pool_key() : fresh_key(1'b0), drain);
      else if (pick < 92) queue_cmd(CMD_DEFRAG, fresh_key(1'b0), drain);
      else if (pick < 95) queue_cmd(CMD_FORMAT, fresh_key(1'b0), drain);
      else if (pick < 98)
        queue_cmd(CMD_W'($urandom_range(CMD_FORMAT + 1, (1 << CMD_W) - 1)), fresh_key(1'b0),
                  drain);
      else queue_cmd(CMD_W'($urandom), {LEAD_W'($urandom), TAIL_W'($urandom)}, drain);
    end

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || in_valid_i || expected_replies.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Command driver: bursts of transfers separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk_i) begin
    logic       next_valid;
    table_cmd_t c;
    next_valid = in_valid_i;
    if (in_valid_i && cmds_accepted == cmds_offered) next_valid = 1'b0;
    if (rst_ni && !next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_backlog.size() > 0 &&
                   !(cmd_backlog[0].drain && expected_replies.size() > 0)) begin
        c = cmd_backlog.pop_front();
        command_i <= c.cmd;
        key_i <= c.key;
        next_valid = 1'b1;
        cmds_offered++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
        end
      end
    end
    in_valid_i <= next_valid;
  end

  // Result receiver: shifting stall patterns and one long hold-off.
  int  rx_cycle = 0;
  int  rx_mode = 0;
  int  rx_phase_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(negedge clk_i) begin
    rx_cycle++;
    if (!hold_done && replies_seen >= 200) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_phase_left = $urandom_range(50, 400);
      end
      rx_phase_left--;
      case (rx_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 1) == 0);
        2: out_stall_i <= ((rx_cycle % 7) < 3);
        default: out_stall_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Monitor: check each result transfer, then record each command transfer.
  always @(posedge clk_i) begin
    table_reply_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      replies_seen++;
      if (expected_replies.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result: status %0d found %0d slot %0d",
                   status_o, found_o, slot_index_o);
      end else begin
        exp_r = expected_replies.pop_front();
        if (status_o !== exp_r.status || found_o !== exp_r.found ||
            slot_index_o !== exp_r.slot) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result %0d mismatch: status %0d/%0d found %0d/%0d slot %0d/%0d",
                     replies_seen, exp_r.status, status_o, exp_r.found, found_o,
                     exp_r.slot, slot_index_o);
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      cmds_accepted++;
      expected_replies.push_back(apply_table_cmd(command_i, key_i));
    end
  end

endmodule

// ===== files.f =====
rtl/core/ktc_pkg.sv
rtl/core/ktc_ram.sv
rtl/core/key_table_with_compaction_top.sv
tb/tb.sv
